// File: rtl/oaids_pkg.sv
// Shared types and constants for the ordered array insert/delete/search core.
// No dependencies; imported by oaids_cell and the top level.
package oaids_pkg;

    localparam int DEPTH_DEF = 64;

    // Fixed field widths of the request and result
    localparam int VAL_W  = 32;
    localparam int POS_W  = 7;
    localparam int FIDX_W = 6;
    localparam int ECNT_W = 7;

    // Search scan looks at this many cells per cycle
    localparam int GRP   = 8;
    localparam int GRP_W = $clog2(GRP);

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_SEARCH = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BADPOS   = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    // Per-cell load controls; at most one load is set in a cycle
    typedef struct packed {
        logic ld_value;
        logic ld_left;
        logic ld_right;
        logic srch;
    } cell_ctl_t;

endpackage

// File: rtl/oaids_cell.sv
// One storage cell of the entry chain: holds a single entry and a match flag.
// Depends on oaids_pkg.
module oaids_cell
    import oaids_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctl_t               ctl,
    input  logic signed [VAL_W-1:0] value,
    input  logic signed [VAL_W-1:0] left_entry,
    input  logic signed [VAL_W-1:0] right_entry,
    output logic signed [VAL_W-1:0] entry,
    output logic                    hit
);

    logic signed [VAL_W-1:0] entry_reg, entry_next;
    logic                    hit_reg, hit_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ld_value)
        begin
            entry_next = value;
        end
        else if (ctl.ld_left)
        begin
            entry_next = left_entry;
        end
        else if (ctl.ld_right)
        begin
            entry_next = right_entry;
        end
    end

    assign hit_next = ctl.srch ? (entry_reg == value) : hit_reg;

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

// File: rtl/ordered_array_insert_delete_search_core.sv
// Ordered array core: a row of DEPTH cells keeps signed 32-bit entries packed
// at indices 0..count-1. On insert and delete the cells from the addressed
// position upward load from their left or right neighbor (or the new value)
// in parallel, so read, insert and delete requests can be accepted back to
// back. A search first latches a match flag in every cell, then a scanner
// walks the flags eight cells per cycle and stops at the first hit or after
// the last group. One result per request; the result register frees up in
// the cycle its result is taken, so a new request can enter in that same
// cycle, while a stalled result holds off new requests.
// Depends on oaids_pkg and oaids_cell.
module ordered_array_insert_delete_search_core
    import oaids_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // request channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               req_type,
    input  logic signed [VAL_W-1:0]  value,
    input  logic [POS_W-1:0]         position,
    // result channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic signed [VAL_W-1:0]  read_value,
    output logic [FIDX_W-1:0]        found_index,
    output logic [ECNT_W-1:0]        entry_count
);

    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int PW   = ((CNTW > POS_W) ? CNTW : POS_W) + 1;   // compare width
    localparam int NGRP = (DEPTH + GRP - 1) / GRP;
    localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int FLW  = NGRP * GRP;
    localparam int FIW  = GW + GRP_W;                           // full match index

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNTW-1:0]         count_reg, count_next;
    logic [GW-1:0]           grp_reg, grp_next;
    logic                    out_valid_reg, out_valid_next;
    status_t                 status_reg, status_next;
    logic signed [VAL_W-1:0] read_value_reg, read_value_next;
    logic [FIDX_W-1:0]       found_index_reg, found_index_next;
    logic [ECNT_W-1:0]       entry_count_reg, entry_count_next;

    logic                    in_acc;
    req_type_t               req;
    logic [PW-1:0]           pos_ext, cnt_ext, p_idx;
    logic                    pos_zero, rd_bad, ins_bad, is_full;

    cell_ctl_t               ctl [DEPTH];
    logic signed [VAL_W-1:0] ent [DEPTH];
    logic [DEPTH-1:0]        hit;
    logic signed [VAL_W-1:0] rd_sel;
    logic [FLW-1:0]          flags;
    logic [GRP-1:0]          gflags;
    logic                    g_any;
    logic [GRP_W-1:0]        g_k;
    logic [FIW-1:0]          match_idx;
    logic [FIW+FIDX_W-1:0]   match_wide;
    logic [CNTW+ECNT_W-1:0]  cnt_wide;

    // handshake: one request in flight; a held result only blocks if stalled
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_acc   = in_valid && !in_stall;
    assign req      = req_type_t'(req_type);

    // position checks against the current count
    assign pos_ext  = PW'(position);
    assign cnt_ext  = PW'(count_reg);
    assign p_idx    = pos_ext - PW'(1);
    assign pos_zero = (position == '0);
    assign rd_bad   = pos_zero || (pos_ext > cnt_ext);
    assign ins_bad  = pos_zero || (pos_ext > (cnt_ext + PW'(1)));
    assign is_full  = (count_reg == CNTW'(DEPTH));

    // per-cell controls: insert shifts up from the target, delete shifts down
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ctl[i] = '0;
            if (in_acc)
            begin
                case (req)
                    REQ_INSERT:
                    begin
                        if (!ins_bad && !is_full)
                        begin
                            ctl[i].ld_value = (PW'(i) == p_idx);
                            ctl[i].ld_left  = (PW'(i) > p_idx);
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (!rd_bad)
                        begin
                            ctl[i].ld_right = (PW'(i) >= p_idx) && (i < DEPTH - 1);
                        end
                    end
                    REQ_SEARCH:
                    begin
                        ctl[i].srch = 1'b1;
                    end
                    default:
                    begin
                        ctl[i] = '0;
                    end
                endcase
            end
        end
    end

    generate
        for (genvar gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [VAL_W-1:0] left_w, right_w;

            if (gi == 0)
            begin : g_first
                assign left_w = ent[gi];
            end
            else
            begin : g_mid_l
                assign left_w = ent[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_w = ent[gi];
            end
            else
            begin : g_mid_r
                assign right_w = ent[gi+1];
            end

            oaids_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl[gi]),
                .value       (value),
                .left_entry  (left_w),
                .right_entry (right_w),
                .entry       (ent[gi]),
                .hit         (hit[gi])
            );
        end
    endgenerate

    // read: AND-OR select of the addressed cell
    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (PW'(i) == p_idx)
            begin
                rd_sel = rd_sel | ent[i];
            end
        end
    end

    // search scan: match flags limited to live entries, one group per cycle
    always_comb
    begin
        flags = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            flags[i] = hit[i] && (CNTW'(i) < count_reg);
        end
    end

    assign gflags = flags[grp_reg*GRP +: GRP];

    always_comb
    begin
        g_any = 1'b0;
        g_k   = '0;
        for (int k = GRP - 1; k >= 0; k--)
        begin
            if (gflags[k])
            begin
                g_any = 1'b1;
                g_k   = GRP_W'(k);
            end
        end
    end

    assign match_idx  = {grp_reg, g_k};
    assign match_wide = {{FIDX_W{1'b0}}, match_idx};

    // next state and result register
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        grp_next         = grp_reg;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        read_value_next  = read_value_reg;
        found_index_next = found_index_reg;

        if (in_acc)
        begin
            case (req)
                REQ_READ:
                begin
                    out_valid_next   = 1'b1;
                    status_next      = rd_bad ? STAT_BADPOS : STAT_OK;
                    read_value_next  = rd_bad ? '0 : rd_sel;
                    found_index_next = '0;
                end
                REQ_INSERT:
                begin
                    out_valid_next   = 1'b1;
                    read_value_next  = '0;
                    found_index_next = '0;
                    if (ins_bad)
                    begin
                        status_next = STAT_BADPOS;
                    end
                    else if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        status_next = STAT_OK;
                        count_next  = count_reg + CNTW'(1);
                    end
                end
                REQ_DELETE:
                begin
                    out_valid_next   = 1'b1;
                    read_value_next  = '0;
                    found_index_next = '0;
                    status_next      = rd_bad ? STAT_BADPOS : STAT_OK;
                    if (!rd_bad)
                    begin
                        count_next = count_reg - CNTW'(1);
                    end
                end
                REQ_SEARCH:
                begin
                    state_next = S_SCAN;
                    grp_next   = '0;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end

        if (state_reg == S_SCAN)
        begin
            if (g_any)
            begin
                state_next       = S_IDLE;
                out_valid_next   = 1'b1;
                status_next      = STAT_OK;
                read_value_next  = '0;
                found_index_next = match_wide[FIDX_W-1:0];
            end
            else if (grp_reg == GW'(NGRP - 1))
            begin
                state_next       = S_IDLE;
                out_valid_next   = 1'b1;
                status_next      = STAT_NOTFOUND;
                read_value_next  = '0;
                found_index_next = '0;
            end
            else
            begin
                grp_next = grp_reg + GW'(1);
            end
        end
    end

    // reported count is the low bits of the count after the request
    assign cnt_wide         = {{ECNT_W{1'b0}}, count_next};
    assign entry_count_next = (out_valid_next && !(out_valid_reg && out_stall))
                              ? cnt_wide[ECNT_W-1:0] : entry_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            grp_reg         <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= STAT_OK;
            read_value_reg  <= '0;
            found_index_reg <= '0;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            grp_reg         <= grp_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            read_value_reg  <= read_value_next;
            found_index_reg <= found_index_next;
            entry_count_reg <= entry_count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign found_index = found_index_reg;
    assign entry_count = entry_count_reg;

    // count never goes past the array size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(DEPTH))
        else $error("entry count above depth");

    // no request is taken while a search scan runs
    a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> in_stall)
        else $error("request accepted during scan");

    // a good insert grows the count by one
    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && req == REQ_INSERT && !ins_bad && !is_full)
        |=> (count_reg == $past(count_reg) + CNTW'(1)))
        else $error("insert did not grow count");

    // a miss reports index zero
    a_miss_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STAT_NOTFOUND) |-> (found_index_reg == '0))
        else $error("miss with nonzero index");

endmodule

// File: dv/ordered_array_insert_delete_search_core_tb.sv
// Testbench for ordered_array_insert_delete_search_core: read, insert, delete and search
// requests checked against a behavioral array model, under random idling and stalls.
// Depends on oaids_pkg and the core RTL.
module ordered_array_insert_delete_search_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import oaids_pkg::*;

    localparam int CAP          = DEPTH_DEF;
    localparam int MIX_ITEMS    = 320;      // random requests per idling phase
    localparam int SETTLE_CYC   = 40;       // covers the longest search scan plus slack
    localparam int CYCLE_LIMIT  = 600000;

    // Expected result of one request
    typedef struct {
        status_t                  st;
        logic signed [VAL_W-1:0]  rd;
        logic [FIDX_W-1:0]        idx;
        logic [ECNT_W-1:0]        cnt;
    } array_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [1:0]               req_type;
    logic signed [VAL_W-1:0]  value;
    logic [POS_W-1:0]         position;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               status;
    logic signed [VAL_W-1:0]  read_value;
    logic [FIDX_W-1:0]        found_index;
    logic [ECNT_W-1:0]        entry_count;

    // Shadow copy of the array, updated when a request is accepted
    logic signed [VAL_W-1:0]  array_model [CAP];
    int                       model_count = 0;
    array_result_t            result_q[$];
    array_result_t            head;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    ordered_array_insert_delete_search_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .read_value  (read_value),
        .found_index (found_index),
        .entry_count (entry_count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver back-pressure, one decision per cycle
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, result_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Apply one accepted request to the shadow array and queue its result
    task automatic predict_result(req_type_t op, logic signed [VAL_W-1:0] val,
                                  logic [POS_W-1:0] pos);
        array_result_t r;
        int p;
        r.st  = STAT_OK;
        r.rd  = '0;
        r.idx = '0;
        p = int'(pos);
        case (op)
            REQ_READ:
            begin
                if (p < 1 || p > model_count)
                    r.st = STAT_BADPOS;
                else
                    r.rd = array_model[p-1];
            end
            REQ_INSERT:
            begin
                // position check wins over the full check
                if (p < 1 || p > model_count + 1)
                    r.st = STAT_BADPOS;
                else if (model_count >= CAP)
                    r.st = STAT_FULL;
                else
                begin
                    for (int i = model_count; i > p - 1; i--)
                        array_model[i] = array_model[i-1];
                    array_model[p-1] = val;
                    model_count++;
                end
            end
            REQ_DELETE:
            begin
                if (p < 1 || p > model_count)
                    r.st = STAT_BADPOS;
                else
                begin
                    for (int i = p - 1; i < model_count - 1; i++)
                        array_model[i] = array_model[i+1];
                    model_count--;
                end
            end
            default:
            begin
                // first match wins; miss leaves index at zero
                r.st = STAT_NOTFOUND;
                for (int i = 0; i < model_count; i++)
                begin
                    if (r.st == STAT_NOTFOUND && array_model[i] == val)
                    begin
                        r.st  = STAT_OK;
                        r.idx = FIDX_W'(i);
                    end
                end
            end
        endcase
        r.cnt = ECNT_W'(model_count);
        result_q.push_back(r);
    endtask

    // Drive one request: random idle gap, then hold until accepted
    task automatic send_request(req_type_t op, logic signed [VAL_W-1:0] val,
                                logic [POS_W-1:0] pos);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op;
        value    <= val;
        position <= pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_result(op, val, pos);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // Valid position in 1..hi, biased toward both ends; 1 when the range is empty
    function automatic logic [POS_W-1:0] pick_pos(int hi);
        int r;
        r = $urandom_range(99);
        if (hi < 1)
            return POS_W'(1);
        if (r < 15)
            return POS_W'(hi);
        if (r < 25)
            return POS_W'(1);
        return POS_W'(1 + $urandom_range(hi - 1));
    endfunction

    // Small pool gives duplicates and search hits; extremes and full-range fill the rest
    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        logic signed [VAL_W-1:0] v;
        r = $urandom_range(99);
        if (r < 45)
            v = $signed(32'($urandom_range(9))) - 32'sd5;
        else if (r < 55)
        begin
            case ($urandom_range(3))
                0:       v = 32'sh80000000;
                1:       v = 32'sh7fffffff;
                2:       v = -32'sd1;
                default: v = 32'sd0;
            endcase
        end
        else
            v = $signed($urandom);
        return v;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_search_value();
        if (model_count > 0 && $urandom_range(99) < 60)
            return array_model[$urandom_range(model_count - 1)];
        return pick_value();
    endfunction

    // Empty-array errors, bad positions, extreme values, duplicates, front/back edits
    task automatic test_directed_cases();
        set_idling(0, 0);
        send_request(REQ_READ,   32'sd0, 7'd0);
        send_request(REQ_READ,   32'sd0, 7'd1);
        send_request(REQ_DELETE, 32'sd0, 7'd1);
        send_request(REQ_SEARCH, 32'sd0, 7'd0);
        send_request(REQ_INSERT, 32'sd9, 7'd0);
        send_request(REQ_INSERT, 32'sd9, 7'd2);
        send_request(REQ_INSERT, 32'sh80000000, 7'd1);
        send_request(REQ_INSERT, 32'sh7fffffff, 7'd2);
        send_request(REQ_INSERT, -32'sd1, 7'd1);
        send_request(REQ_INSERT, 32'sd0, 7'd2);
        send_request(REQ_INSERT, -32'sd1, 7'd3);
        send_request(REQ_READ,   32'sd0, 7'd1);
        send_request(REQ_READ,   32'sd0, 7'd5);
        send_request(REQ_READ,   32'sd0, 7'd6);
        send_request(REQ_READ,   32'sd0, 7'd127);
        send_request(REQ_SEARCH, -32'sd1, 7'd0);
        send_request(REQ_SEARCH, 32'sh80000000, 7'd127);
        send_request(REQ_SEARCH, 32'sd12345, 7'd0);
        send_request(REQ_DELETE, 32'sd0, 7'd1);
        send_request(REQ_DELETE, 32'sd0, 7'd4);
        send_request(REQ_DELETE, 32'sd0, 7'd4);
        send_request(REQ_DELETE, 32'sd0, 7'd0);
        send_request(REQ_SEARCH, -32'sd1, 7'd0);
        send_request(REQ_INSERT, -32'sd1, 7'd127);
        wait_for_results();
    endtask

    // Fill to capacity, poke the full array, then empty it again
    task automatic test_fill_to_full();
        set_idling(0, 86);
        while (model_count < CAP)
            send_request(REQ_INSERT, $signed($urandom), pick_pos(model_count + 1));
        send_request(REQ_INSERT, pick_value(), 7'd1);
        send_request(REQ_INSERT, pick_value(), POS_W'(CAP + 1));
        send_request(REQ_INSERT, pick_value(), POS_W'(CAP + 2));
        send_request(REQ_INSERT, pick_value(), 7'd0);
        send_request(REQ_READ,   32'sd0, POS_W'(CAP));
        send_request(REQ_READ,   32'sd0, POS_W'(CAP + 1));
        // deep scan: last cell, and a likely miss over the whole row
        send_request(REQ_SEARCH, array_model[CAP-1], 7'd0);
        send_request(REQ_SEARCH, $signed($urandom), 7'd0);
        send_request(REQ_DELETE, 32'sd0, POS_W'(CAP + 1));
        send_request(REQ_DELETE, 32'sd0, POS_W'(CAP));
        send_request(REQ_INSERT, 32'sh7fffffff, POS_W'(CAP));
        wait_for_results();

        set_idling(86, 0);
        while (model_count > 0)
        begin
            if ($urandom_range(99) < 20)
                send_request(REQ_SEARCH, pick_search_value(), pick_pos(model_count));
            send_request(REQ_DELETE, pick_value(), pick_pos(model_count));
        end
        send_request(REQ_SEARCH, 32'sh7fffffff, 7'd0);
        wait_for_results();
    endtask

    // Mixed traffic; insert bias swings high, even, low so the count sweeps its range
    task automatic test_random_mix();
        int grow;
        int r;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       set_idling(0, 0);
                1:       set_idling(86, 0);
                2:       set_idling(0, 86);
                default: set_idling(22, 22);
            endcase
            for (int n = 0; n < MIX_ITEMS; n++)
            begin
                grow = (n < MIX_ITEMS / 3) ? 85 : (n < 2 * MIX_ITEMS / 3) ? 50 : 15;
                r = $urandom_range(99);
                if (r < 8)
                    send_request(req_type_t'($urandom_range(3)), $signed($urandom),
                                 POS_W'($urandom_range(127)));
                else if (r < 22)
                    send_request(REQ_READ, pick_value(), pick_pos(model_count));
                else if (r < 36)
                    send_request(REQ_SEARCH, pick_search_value(), pick_pos(model_count));
                else if ($urandom_range(99) < grow)
                    send_request(REQ_INSERT, pick_value(), pick_pos(model_count + 1));
                else
                    send_request(REQ_DELETE, pick_value(), pick_pos(model_count));
            end
            wait_for_results();
        end
    endtask

    // Result checker: every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d read_value=%0d index=%0d count=%0d",
                         $time, status, read_value, found_index, entry_count);
                fail_count++;
            end
            else
            begin
                head = result_q.pop_front();
                if (status !== head.st)
                begin
                    $display("%0t: status expected %0d, got %0d", $time, head.st, status);
                    fail_count++;
                end
                if (read_value !== head.rd)
                begin
                    $display("%0t: read_value expected %0d, got %0d",
                             $time, head.rd, read_value);
                    fail_count++;
                end
                if (found_index !== head.idx)
                begin
                    $display("%0t: found_index expected %0d, got %0d",
                             $time, head.idx, found_index);
                    fail_count++;
                end
                if (entry_count !== head.cnt)
                begin
                    $display("%0t: entry_count expected %0d, got %0d",
                             $time, head.cnt, entry_count);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_READ;
        value    = '0;
        position = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_fill_to_full();
        test_random_mix();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
